// File: sv/bnf_pkg.sv
package bnf_pkg;

    // op codes carried in the input tuser field
    localparam logic [2:0] OP_SET_SCALE = 3'd0;
    localparam logic [2:0] OP_SET_SHIFT = 3'd1;
    localparam logic [2:0] OP_SET_MEAN  = 3'd2;
    localparam logic [2:0] OP_SET_VAR   = 3'd3;
    localparam logic [2:0] OP_INFER     = 3'd4;
    localparam logic [2:0] OP_TRAIN     = 3'd5;

    // configuration register indexes
    localparam logic [0:0] CFG_EPSILON  = 1'b0;
    localparam logic [0:0] CFG_MOMENTUM = 1'b1;

    localparam int CFG_DATA_W = 17;

    // request to the shared divide / square root unit
    typedef struct packed {
        logic        start;
        logic        sqrt_mode;
        logic [63:0] a;
        logic [31:0] b;
    } arith_req_t;

    // answer of the shared unit
    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } arith_rsp_t;

endpackage

// File: sv/batch_norm_forward.sv
// Per-feature batch normalization, signed Q16.16.
// Input stream: tuser = op (set scale/shift/mean/variance, infer, train sample),
// tdata = feature index and sample value, tlast = end of a training batch.
// Result stream: tdata = normalized value, tlast = last result of a run,
// tuser = overflow flag of a batch that had samples dropped.
// Configuration: cfg_we/cfg_index/cfg_wdata write epsilon and momentum.
// An inference item runs the 32-step root and then the 64-step divide on
// the shared iterative unit. A batch runs the mean and variance divides,
// one root, then a multiply and 64-step divide per sample, then the
// running statistics blend.
// After reset the tables are swept to their reset values, one row a cycle,
// and s_tready stays low during the sweep.
// A two entry queue parts the input side from the sequencer, and a result
// register parts it from the output; when the receiver stalls the result is
// held and the sequencer waits, while the queue keeps taking items until full.
module batch_norm_forward
    import bnf_pkg::*;
#(
    parameter int FEATURES  = 256,
    parameter int BATCH_MAX = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [39:0]           s_tdata,   // feature [7:0], sample_value [39:8]
    input  logic                  s_tlast,
    input  logic [2:0]            s_tuser,   // op [2:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // result_value [31:0]
    output logic                  m_tlast,
    output logic                  m_tuser,   // overflow [0]
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int FW     = (FEATURES > 1) ? $clog2(FEATURES) : 1;
    localparam int ITEM_W = FW + 36;

    logic              q_push, q_pop, q_full, q_empty, clearing;
    logic [ITEM_W-1:0] q_data, q_head;
    arith_req_t        arith_req;
    arith_rsp_t        arith_rsp;

    bnf_front #(.FEATURES(FEATURES)) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .clearing (clearing),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_data)
    );

    bnf_fifo #(.WIDTH(ITEM_W)) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    bnf_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (arith_req),
        .rsp     (arith_rsp)
    );

    bnf_back #(.FEATURES(FEATURES), .BATCH_MAX(BATCH_MAX)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .arith_req (arith_req),
        .arith_rsp (arith_rsp),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .clearing  (clearing)
    );

    // no transfer is taken while the tables are swept
    a_clear_no_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !s_tready)
        else $error("input taken during table sweep");

    // no result comes out of reset
    a_reset_no_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // the queue is never written when full
    a_queue_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("queue overrun");

    // the queue is not drained while the sweep runs
    a_clear_no_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !q_pop && !m_tvalid)
        else $error("item worked during table sweep");

endmodule

// File: sv/bnf_front.sv
module bnf_front
    import bnf_pkg::*;
#(
    parameter int FEATURES = 256
) (
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [39:0]             s_tdata,
    input  logic                    s_tlast,
    input  logic [2:0]              s_tuser,
    input  logic                    clearing,
    input  logic                    q_full,
    output logic                    q_push,
    output logic [((FEATURES > 1) ? $clog2(FEATURES) : 1) + 35:0] q_data
);

    localparam int FW     = (FEATURES > 1) ? $clog2(FEATURES) : 1;
    localparam int ITEM_W = FW + 36;

    logic [FW-1:0] mod_lut [256];
    logic          keep;

    // feature index folded into the table depth
    for (genvar g = 0; g < 256; g++) begin : g_mod
        assign mod_lut[g] = FW'(g % FEATURES);
    end

    // unused op codes are taken and dropped
    assign keep     = s_tuser inside {[OP_SET_SCALE:OP_TRAIN]};
    assign s_tready = !q_full && !clearing;
    assign q_push   = s_tvalid && s_tready && keep;
    assign q_data   = {s_tlast, s_tdata[39:8], mod_lut[s_tdata[7:0]], s_tuser};

endmodule

// File: sv/bnf_fifo.sv
module bnf_fifo #(
    parameter int WIDTH = 44
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    // two entry queue between front and back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: sv/bnf_arith.sv
module bnf_arith
    import bnf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  arith_req_t req,
    output arith_rsp_t rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic        mode_reg;
    logic [6:0]  cnt_reg;
    logic [34:0] rem_reg;
    logic [63:0] quo_reg;
    logic [63:0] opnd_reg;
    logic [31:0] div_reg;

    logic [32:0] rem_sh_d;
    logic [32:0] sub_d;
    logic        ge_d;
    logic [34:0] rem_sh_s;
    logic [34:0] trial_s;
    logic        ge_s;

    // restoring divide step: one quotient bit
    assign rem_sh_d = {rem_reg[31:0], quo_reg[63]};
    assign sub_d    = rem_sh_d - {1'b0, div_reg};
    assign ge_d     = (rem_sh_d >= {1'b0, div_reg});

    // digit by digit root step: one root bit
    assign rem_sh_s = {rem_reg[32:0], opnd_reg[63:62]};
    assign trial_s  = {1'b0, quo_reg[31:0], 2'b01};
    assign ge_s     = (rem_sh_s >= trial_s);

    assign rsp.done   = done_reg;
    assign rsp.result = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == 7'd1) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            mode_reg <= req.sqrt_mode;
            cnt_reg  <= req.sqrt_mode ? 7'd32 : 7'd64;
            rem_reg  <= '0;
            quo_reg  <= req.sqrt_mode ? 64'd0 : req.a;
            opnd_reg <= req.a;
            div_reg  <= req.b;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 7'd1;
            if (mode_reg) begin
                rem_reg  <= ge_s ? (rem_sh_s - trial_s) : rem_sh_s;
                quo_reg  <= {quo_reg[62:0], ge_s};
                opnd_reg <= {opnd_reg[61:0], 2'b00};
            end else begin
                rem_reg <= {2'b00, (ge_d ? sub_d : rem_sh_d)};
                quo_reg <= {quo_reg[62:0], ge_d};
            end
        end
    end

endmodule

// File: sv/bnf_back.sv
module bnf_back
    import bnf_pkg::*;
#(
    parameter int FEATURES  = 256,
    parameter int BATCH_MAX = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  q_empty,
    input  logic [((FEATURES > 1) ? $clog2(FEATURES) : 1) + 35:0] q_head,
    output logic                  q_pop,
    output arith_req_t            arith_req,
    input  arith_rsp_t            arith_rsp,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,
    output logic                  m_tlast,
    output logic                  m_tuser,
    output logic                  clearing
);

    localparam int FW     = (FEATURES > 1) ? $clog2(FEATURES) : 1;
    localparam int ITEM_W = FW + 36;
    localparam int CNT_W  = $clog2(BATCH_MAX + 1);
    localparam int IDX_W  = (BATCH_MAX > 1) ? $clog2(BATCH_MAX) : 1;
    localparam int ACC_W  = 48 + CNT_W;

    localparam logic [4:0] ST_CLEAR    = 5'd0;
    localparam logic [4:0] ST_IDLE     = 5'd1;
    localparam logic [4:0] ST_DECODE   = 5'd2;
    localparam logic [4:0] ST_FETCH    = 5'd3;
    localparam logic [4:0] ST_MEAN     = 5'd4;
    localparam logic [4:0] ST_MEAN_W   = 5'd5;
    localparam logic [4:0] ST_VAR_RD   = 5'd6;
    localparam logic [4:0] ST_VAR_MUL  = 5'd7;
    localparam logic [4:0] ST_VAR_ACC  = 5'd8;
    localparam logic [4:0] ST_VAR_DIV  = 5'd9;
    localparam logic [4:0] ST_VAR_W    = 5'd10;
    localparam logic [4:0] ST_ROOT     = 5'd11;
    localparam logic [4:0] ST_ROOT_W   = 5'd12;
    localparam logic [4:0] ST_SMP_RD   = 5'd13;
    localparam logic [4:0] ST_SMP_LD   = 5'd14;
    localparam logic [4:0] ST_NORM_MUL = 5'd15;
    localparam logic [4:0] ST_NORM_DIV = 5'd16;
    localparam logic [4:0] ST_NORM_W   = 5'd17;
    localparam logic [4:0] ST_NORM_OUT = 5'd18;
    localparam logic [4:0] ST_BL_M1    = 5'd19;
    localparam logic [4:0] ST_BL_M2    = 5'd20;
    localparam logic [4:0] ST_BL_M3    = 5'd21;
    localparam logic [4:0] ST_BL_V2    = 5'd22;
    localparam logic [4:0] ST_BL_V3    = 5'd23;

    localparam logic signed [57:0] S_MAX = 58'sd281474976710655;

    function automatic logic [31:0] mag33(input logic signed [32:0] d);
        logic signed [32:0] n;
        n = -d;
        return d[32] ? n[31:0] : d[31:0];
    endfunction

    function automatic logic [31:0] sat67(input logic signed [66:0] v);
        if (v > 67'sd2147483647) begin
            return 32'h7fff_ffff;
        end else if (v < -67'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // tables and batch buffer
    logic signed [31:0] scale_mem [FEATURES];
    logic signed [31:0] shift_mem [FEATURES];
    logic signed [31:0] mean_mem  [FEATURES];
    logic signed [31:0] var_mem   [FEATURES];
    logic signed [31:0] buf_mem   [BATCH_MAX];

    logic signed [31:0] scale_rd_reg, shift_rd_reg, mean_rd_reg, var_rd_reg, buf_rd_reg;

    logic [4:0]          state_reg, state_next;
    logic [FW-1:0]       clr_idx_reg;
    logic [ITEM_W-1:0]   item_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic signed [39:0]  sum_reg;
    logic                ovf_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic signed [31:0]  mean_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic signed [56:0]  var_n_reg;
    logic [31:0]         sd_reg;
    logic signed [31:0]  x_reg, mean_n_reg;
    logic signed [31:0]  gamma_reg, beta_reg, omean_reg, ovar_reg;
    logic                neg_reg;
    logic [63:0]         q_reg;
    logic signed [65:0]  p1_reg, prod_reg;
    logic [15:0]         eps_reg;
    logic [16:0]         mom_reg;
    logic                m_tvalid_reg, m_tlast_reg, m_tuser_reg;
    logic [31:0]         m_tdata_reg;

    logic [2:0]          it_op;
    logic [FW-1:0]       it_feat;
    logic signed [31:0]  it_val;
    logic                it_end;
    logic                room;
    logic                idx_last;
    logic                out_free;
    logic [39:0]         abs_sum;
    logic signed [57:0]  s_raw, s_cl;
    logic signed [32:0]  d_v, d_n;
    logic [31:0]         mag_v, mag_n, mag_g;
    logic [16:0]         m_eff, one_m;
    logic [31:0]         var_sat;
    logic signed [32:0]  mul_x, mul_y;
    logic signed [65:0]  qs;
    logic signed [66:0]  norm_tot, bl_tot, bl_adj;
    logic [31:0]         norm_out, blend_out;
    logic                we_scale, we_shift, we_mean, we_var, buf_we;
    logic [FW-1:0]       tbl_addr;
    logic signed [31:0]  wd_scale, wd_shift, wd_mean, wd_var;

    assign it_op   = item_reg[2:0];
    assign it_feat = item_reg[FW+2:3];
    assign it_val  = $signed(item_reg[FW+34:FW+3]);
    assign it_end  = item_reg[ITEM_W-1];

    assign room     = (cnt_reg < CNT_W'(BATCH_MAX));
    assign idx_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign clearing = (state_reg == ST_CLEAR);

    assign abs_sum = sum_reg[39] ? 40'(-sum_reg) : 40'(sum_reg);

    // variance plus epsilon, clamped for the root
    assign s_raw = 58'(var_n_reg) + $signed({42'd0, eps_reg});
    assign s_cl  = (s_raw < 58'sd1) ? 58'sd1 : ((s_raw > S_MAX) ? S_MAX : s_raw);

    // deviations and magnitudes
    assign d_v   = 33'(buf_rd_reg) - 33'(mean_reg);
    assign d_n   = 33'(x_reg) - 33'(mean_n_reg);
    assign mag_v = mag33(d_v);
    assign mag_n = mag33(d_n);
    assign mag_g = mag33(33'(gamma_reg));

    assign m_eff   = (mom_reg > 17'd65536) ? 17'd65536 : mom_reg;
    assign one_m   = 17'd65536 - m_eff;
    assign var_sat = (var_n_reg > 57'sd2147483647) ? 32'h7fff_ffff : var_n_reg[31:0];

    // shared multiplier operand select
    always_comb begin
        mul_x = '0;
        mul_y = '0;
        case (state_reg)
            ST_VAR_MUL: begin
                mul_x = $signed({1'b0, mag_v});
                mul_y = $signed({1'b0, mag_v});
            end
            ST_NORM_MUL: begin
                mul_x = $signed({1'b0, mag_n});
                mul_y = $signed({1'b0, mag_g});
            end
            ST_BL_M1: begin
                mul_x = $signed({16'd0, one_m});
                mul_y = 33'(omean_reg);
            end
            ST_BL_M2: begin
                mul_x = $signed({16'd0, m_eff});
                mul_y = 33'(mean_reg);
            end
            ST_BL_M3: begin
                mul_x = $signed({16'd0, one_m});
                mul_y = 33'(ovar_reg);
            end
            ST_BL_V2: begin
                mul_x = $signed({16'd0, m_eff});
                mul_y = $signed({1'b0, var_sat});
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_x * mul_y;
    end

    // output value and blend, truncated toward zero
    assign qs        = neg_reg ? -$signed({2'b00, q_reg}) : $signed({2'b00, q_reg});
    assign norm_tot  = 67'(qs) + 67'(beta_reg);
    assign norm_out  = sat67(norm_tot);
    assign bl_tot    = 67'(p1_reg) + 67'(prod_reg);
    assign bl_adj    = bl_tot[66] ? (bl_tot + 67'sd65535) : bl_tot;
    assign blend_out = sat67(bl_adj >>> 16);

    // requests to the divide / root unit
    always_comb begin
        arith_req.start     = 1'b0;
        arith_req.sqrt_mode = 1'b0;
        arith_req.a         = '0;
        arith_req.b         = '0;
        case (state_reg)
            ST_MEAN: begin
                arith_req.start = 1'b1;
                arith_req.a     = 64'(abs_sum);
                arith_req.b     = 32'(cnt_reg);
            end
            ST_VAR_DIV: begin
                arith_req.start = 1'b1;
                arith_req.a     = 64'(acc_reg);
                arith_req.b     = 32'(cnt_reg);
            end
            ST_ROOT: begin
                arith_req.start     = 1'b1;
                arith_req.sqrt_mode = 1'b1;
                arith_req.a         = {s_cl[47:0], 16'd0};
            end
            ST_NORM_DIV: begin
                arith_req.start = 1'b1;
                arith_req.a     = prod_reg[63:0];
                arith_req.b     = sd_reg;
            end
            default: begin
                arith_req.start = 1'b0;
            end
        endcase
    end

    // table write port select
    always_comb begin
        we_scale = 1'b0;
        we_shift = 1'b0;
        we_mean  = 1'b0;
        we_var   = 1'b0;
        tbl_addr = it_feat;
        wd_scale = it_val;
        wd_shift = it_val;
        wd_mean  = it_val;
        wd_var   = it_val;
        case (state_reg)
            ST_CLEAR: begin
                tbl_addr = clr_idx_reg;
                we_scale = 1'b1;
                we_shift = 1'b1;
                we_mean  = 1'b1;
                we_var   = 1'b1;
                wd_scale = 32'sd65536;
                wd_shift = 32'sd0;
                wd_mean  = 32'sd0;
                wd_var   = 32'sd65536;
            end
            ST_DECODE: begin
                we_scale = (it_op == OP_SET_SCALE);
                we_shift = (it_op == OP_SET_SHIFT);
                we_mean  = (it_op == OP_SET_MEAN);
                we_var   = (it_op == OP_SET_VAR);
            end
            ST_BL_M3: begin
                we_mean = 1'b1;
                wd_mean = blend_out;
            end
            ST_BL_V3: begin
                we_var = 1'b1;
                wd_var = blend_out;
            end
            default: begin
                we_scale = 1'b0;
            end
        endcase
    end

    assign buf_we = (state_reg == ST_DECODE) && (it_op == OP_TRAIN) && room;

    // table memories, registered reads at the current feature
    always_ff @(posedge aclk) begin
        if (we_scale) scale_mem[tbl_addr] <= wd_scale;
        scale_rd_reg <= scale_mem[it_feat];
    end

    always_ff @(posedge aclk) begin
        if (we_shift) shift_mem[tbl_addr] <= wd_shift;
        shift_rd_reg <= shift_mem[it_feat];
    end

    always_ff @(posedge aclk) begin
        if (we_mean) mean_mem[tbl_addr] <= wd_mean;
        mean_rd_reg <= mean_mem[it_feat];
    end

    always_ff @(posedge aclk) begin
        if (we_var) var_mem[tbl_addr] <= wd_var;
        var_rd_reg <= var_mem[it_feat];
    end

    always_ff @(posedge aclk) begin
        if (buf_we) buf_mem[cnt_reg[IDX_W-1:0]] <= it_val;
        buf_rd_reg <= buf_mem[idx_reg];
    end

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:    if (clr_idx_reg == FW'(FEATURES - 1)) state_next = ST_IDLE;
            ST_IDLE:     if (!q_empty) state_next = ST_DECODE;
            ST_DECODE: begin
                if (it_op == OP_INFER || (it_op == OP_TRAIN && it_end)) begin
                    state_next = ST_FETCH;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_FETCH:    state_next = (it_op == OP_INFER) ? ST_ROOT : ST_MEAN;
            ST_MEAN:     state_next = ST_MEAN_W;
            ST_MEAN_W:   if (arith_rsp.done) state_next = ST_VAR_RD;
            ST_VAR_RD:   state_next = ST_VAR_MUL;
            ST_VAR_MUL:  state_next = ST_VAR_ACC;
            ST_VAR_ACC:  state_next = idx_last ? ST_VAR_DIV : ST_VAR_RD;
            ST_VAR_DIV:  state_next = ST_VAR_W;
            ST_VAR_W:    if (arith_rsp.done) state_next = ST_ROOT;
            ST_ROOT:     state_next = ST_ROOT_W;
            ST_ROOT_W: begin
                if (arith_rsp.done) begin
                    state_next = (it_op == OP_INFER) ? ST_NORM_MUL : ST_SMP_RD;
                end
            end
            ST_SMP_RD:   state_next = ST_SMP_LD;
            ST_SMP_LD:   state_next = ST_NORM_MUL;
            ST_NORM_MUL: state_next = ST_NORM_DIV;
            ST_NORM_DIV: state_next = ST_NORM_W;
            ST_NORM_W:   if (arith_rsp.done) state_next = ST_NORM_OUT;
            ST_NORM_OUT: begin
                if (out_free) begin
                    if (it_op == OP_INFER) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = idx_last ? ST_BL_M1 : ST_SMP_RD;
                    end
                end
            end
            ST_BL_M1:    state_next = ST_BL_M2;
            ST_BL_M2:    state_next = ST_BL_M3;
            ST_BL_M3:    state_next = ST_BL_V2;
            ST_BL_V2:    state_next = ST_BL_V3;
            ST_BL_V3:    state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // control state, batch state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_idx_reg  <= '0;
            cnt_reg      <= '0;
            sum_reg      <= '0;
            ovf_reg      <= 1'b0;
            eps_reg      <= 16'd1;
            mom_reg      <= 17'd6554;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_idx_reg <= clr_idx_reg + FW'(1);
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_EPSILON:  eps_reg <= cfg_wdata[15:0];
                    CFG_MOMENTUM: mom_reg <= cfg_wdata;
                    default:      eps_reg <= eps_reg;
                endcase
            end
            // sample buffering
            if (state_reg == ST_DECODE && it_op == OP_TRAIN) begin
                if (room) begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    sum_reg <= sum_reg + 40'(it_val);
                end else begin
                    ovf_reg <= 1'b1;
                end
            end
            if (state_reg == ST_BL_V3) begin
                cnt_reg <= '0;
                sum_reg <= '0;
                ovf_reg <= 1'b0;
            end
            // output register
            if (state_reg == ST_NORM_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) item_reg <= q_head;
            end
            ST_FETCH: begin
                gamma_reg  <= scale_rd_reg;
                beta_reg   <= shift_rd_reg;
                omean_reg  <= mean_rd_reg;
                ovar_reg   <= var_rd_reg;
                x_reg      <= it_val;
                mean_n_reg <= mean_rd_reg;
                var_n_reg  <= 57'(var_rd_reg);
            end
            ST_MEAN_W: begin
                if (arith_rsp.done) begin
                    mean_reg   <= sum_reg[39] ? (~arith_rsp.result[31:0] + 32'd1)
                                              : arith_rsp.result[31:0];
                    mean_n_reg <= sum_reg[39] ? (~arith_rsp.result[31:0] + 32'd1)
                                              : arith_rsp.result[31:0];
                    acc_reg    <= '0;
                    idx_reg    <= '0;
                end
            end
            ST_VAR_ACC: begin
                acc_reg <= acc_reg + ACC_W'(prod_reg[63:16]);
                idx_reg <= idx_reg + IDX_W'(1);
            end
            ST_VAR_W: begin
                if (arith_rsp.done) var_n_reg <= 57'(arith_rsp.result[ACC_W-1:0]);
            end
            ST_ROOT_W: begin
                if (arith_rsp.done) begin
                    sd_reg  <= arith_rsp.result[31:0];
                    idx_reg <= '0;
                end
            end
            ST_SMP_LD: begin
                x_reg <= buf_rd_reg;
            end
            ST_NORM_MUL: begin
                neg_reg <= d_n[32] ^ gamma_reg[31];
            end
            ST_NORM_W: begin
                if (arith_rsp.done) q_reg <= arith_rsp.result;
            end
            ST_NORM_OUT: begin
                if (out_free) begin
                    m_tdata_reg <= norm_out;
                    m_tlast_reg <= (it_op == OP_INFER) || idx_last;
                    m_tuser_reg <= (it_op == OP_TRAIN) && ovf_reg;
                    idx_reg     <= idx_reg + IDX_W'(1);
                end
            end
            ST_BL_M2: p1_reg <= prod_reg;
            ST_BL_V2: p1_reg <= prod_reg;
            default: begin
                p1_reg <= p1_reg;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: verif/tb_batch_norm_forward.sv
`timescale 1ns / 100ps

module tb_batch_norm_forward
    import bnf_pkg::*;
();

    localparam int FEATURES  = 256;
    localparam int BATCH_MAX = 64;
    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;
    localparam longint S_MAX = (longint'(1) << 48) - 1;
    localparam int ONE_Q16 = 65536;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 400;

    typedef struct {
        logic [2:0]  op;
        logic [7:0]  feature;
        logic [31:0] value;
        logic        batch_end;
    } bn_item_t;

    typedef struct {
        logic [31:0] value;
        logic        last;
        logic        overflow;
    } bn_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [39:0]           s_tdata = '0;   // feature [7:0], sample_value [39:8]
    logic                  s_tlast = 1'b0;
    logic [2:0]            s_tuser = '0;   // op [2:0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [31:0]           m_tdata;        // result_value [31:0]
    logic                  m_tlast;
    logic                  m_tuser;        // overflow [0]
    logic                  cfg_we = 1'b0;
    logic [0:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    batch_norm_forward #(.FEATURES(FEATURES), .BATCH_MAX(BATCH_MAX)) uut (.*);

    // predictor state
    int          scale_tab [FEATURES];
    int          shift_tab [FEATURES];
    int          rmean_tab [FEATURES];
    int          rvar_tab  [FEATURES];
    int          samples   [BATCH_MAX];
    int unsigned sample_cnt;
    longint      sample_sum;
    bit          dropped;
    int unsigned eps_q16;
    int unsigned mom_q16;

    bn_item_t   pending_items[$];
    bn_result_t expected_results[$];
    bn_item_t   cur_item;

    int errors = 0;
    int n_items = 0;
    int n_results = 0;
    int n_batches = 0;
    int cyc = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit quiet;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // idle-free window in the middle of the run
    assign quiet = (cyc >= 3000) && (cyc < 6000);

    function automatic bit [63:0] int_sqrt(bit [63:0] v);
        bit [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic bit [63:0] magnitude(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic int sat32(longint v);
        if (v > 64'sh7fffffff) return 32'h7fffffff;
        if (v < -64'sh80000000) return 32'h80000000;
        return int'(v);
    endfunction

    function automatic int norm_value(longint x, longint mean, longint var_q,
                                      longint gamma, longint beta);
        longint    s, d, r;
        bit [63:0] sd, q;
        s = var_q + longint'(eps_q16);
        d = x - mean;
        if (s < 1) s = 1;
        if (s > S_MAX) s = S_MAX;
        sd = int_sqrt(64'(s) << 16);
        q = (magnitude(d) * magnitude(gamma)) / sd;
        r = ((d < 0) != (gamma < 0)) ? -longint'(q) : longint'(q);
        return sat32(r + beta);
    endfunction

    function automatic int blend_stat(longint old, longint now);
        longint m;
        m = (mom_q16 > ONE_Q16) ? ONE_Q16 : mom_q16;
        return sat32(((ONE_Q16 - m) * old + m * now) / ONE_Q16);
    endfunction

    // expected results for one accepted input transfer
    task automatic predict_item(bn_item_t it);
        int          f;
        longint      x, mean, var_q;
        bit [63:0]   acc, d;
        bn_result_t  r;
        f = it.feature % FEATURES;
        x = longint'(signed'(it.value));
        n_items++;
        case (it.op)
            OP_SET_SCALE: scale_tab[f] = int'(x);
            OP_SET_SHIFT: shift_tab[f] = int'(x);
            OP_SET_MEAN:  rmean_tab[f] = int'(x);
            OP_SET_VAR:   rvar_tab[f]  = int'(x);
            OP_INFER: begin
                r.value = norm_value(x, rmean_tab[f], rvar_tab[f], scale_tab[f], shift_tab[f]);
                r.last = 1'b1;
                r.overflow = 1'b0;
                expected_results.push_back(r);
            end
            OP_TRAIN: begin
                if (sample_cnt < BATCH_MAX) begin
                    samples[sample_cnt] = int'(x);
                    sample_cnt++;
                    sample_sum += x;
                end else begin
                    dropped = 1'b1;
                end
                if (it.batch_end) begin
                    mean = sample_sum / longint'(sample_cnt);
                    acc = 0;
                    for (int i = 0; i < sample_cnt; i++) begin
                        d = magnitude(longint'(samples[i]) - mean);
                        acc += (d * d) >> 16;
                    end
                    var_q = longint'(acc / sample_cnt);
                    for (int i = 0; i < sample_cnt; i++) begin
                        r.value = norm_value(samples[i], mean, var_q, scale_tab[f], shift_tab[f]);
                        r.last = (i + 1 == sample_cnt);
                        r.overflow = dropped;
                        expected_results.push_back(r);
                    end
                    rmean_tab[f] = blend_stat(rmean_tab[f], mean);
                    rvar_tab[f] = blend_stat(rvar_tab[f],
                                             var_q > 64'sh7fffffff ? 64'sh7fffffff : var_q);
                    sample_cnt = 0;
                    sample_sum = 0;
                    dropped = 1'b0;
                    n_batches++;
                end
            end
            default: ;
        endcase
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cyc, what, got, want);
        errors++;
    endtask

    // input driver
    always @(posedge aclk) begin : driver
        bit fire;
        fire = s_tvalid && s_tready;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (fire) predict_item(cur_item);
            if (!s_tvalid || fire) begin
                if (pending_items.size() > 0 && (quiet || $urandom_range(99) >= 28)) begin
                    cur_item = pending_items.pop_front();
                    s_tdata <= {cur_item.value, cur_item.feature};
                    s_tuser <= cur_item.op;
                    s_tlast <= cur_item.batch_end;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver readiness, with one long hold-off once results pile up
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (!hold_done && cyc > 400 && expected_results.size() >= 3) begin
            hold_left <= 1500;
            hold_done <= 1'b1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet || ($urandom_range(99) >= 28);
        end
    end

    // result monitor
    always @(posedge aclk) begin : monitor
        bn_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (expected_results.size() == 0) begin
                report("unexpected result", m_tdata, '0);
            end else begin
                want = expected_results.pop_front();
                if (m_tdata !== want.value) report("result_value", m_tdata, want.value);
                if (m_tlast !== want.last) report("last", m_tlast, want.last);
                if (m_tuser !== want.overflow) report("overflow", m_tuser, want.overflow);
            end
        end
    end

    // cycle count and timeout
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic push_item(logic [2:0] op, logic [7:0] f, logic [31:0] v, logic e);
        bn_item_t it;
        it.op = op;
        it.feature = f;
        it.value = v;
        it.batch_end = e;
        pending_items.push_back(it);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(9))
            0, 1: return $urandom;
            2: return 32'h7fffffff;
            3: return 32'h80000000;
            default: return $urandom_range(8 * ONE_Q16) - 4 * ONE_Q16;
        endcase
    endfunction

    function automatic logic [7:0] rand_feature();
        return ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    endfunction

    task automatic push_batch(int n, logic [7:0] f);
        for (int i = 0; i < n; i++)
            push_item(OP_TRAIN, (i == n - 1) ? f : rand_feature(), rand_value(), i == n - 1);
    endtask

    // wait until all transfers are done and the block has gone quiet
    task automatic drain();
        while (pending_items.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, int unsigned val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_EPSILON) eps_q16 = val & 32'hffff;
        else mom_q16 = val & 32'h1ffff;
    endtask

    task automatic random_phase(int count, bit with_overflow);
        int k, n;
        k = 0;
        if (with_overflow) begin
            push_batch(BATCH_MAX + 3, rand_feature());
            k += BATCH_MAX + 3;
        end
        while (k < count) begin
            case ($urandom_range(19))
                0, 1, 2: begin
                    push_item(3'($urandom_range(3)), rand_feature(),
                              ($urandom_range(3) == 0) ? rand_value()
                                                       : $urandom_range(4 * ONE_Q16),
                              1'($urandom));
                    k++;
                end
                3, 4, 5, 6, 7, 8: begin
                    push_item(OP_INFER, rand_feature(), rand_value(), 1'($urandom));
                    k++;
                end
                9: begin
                    push_item($urandom_range(1) ? OP_UNUSED_6 : OP_UNUSED_7, 8'($urandom),
                              $urandom, 1'($urandom));
                    k++;
                end
                default: begin
                    n = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
                    push_batch(n, rand_feature());
                    k += n;
                end
            endcase
        end
    endtask

    initial begin
        for (int i = 0; i < FEATURES; i++) begin
            scale_tab[i] = ONE_Q16;
            shift_tab[i] = 0;
            rmean_tab[i] = 0;
            rvar_tab[i] = ONE_Q16;
        end
        sample_cnt = 0;
        sample_sum = 0;
        dropped = 1'b0;
        eps_q16 = 1;
        mom_q16 = 6554;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset tables, extremes, ignored codes and flags
        push_item(OP_INFER, 8'd0, 32'h7fffffff, 1'b0);
        push_item(OP_INFER, 8'd255, 32'h80000000, 1'b1);
        push_item(OP_SET_SCALE, 8'd1, 32'h80000000, 1'b0);
        push_item(OP_SET_SHIFT, 8'd1, 32'h7fffffff, 1'b0);
        push_item(OP_INFER, 8'd1, 32'h00010000, 1'b0);
        push_item(OP_SET_VAR, 8'd2, 32'h80000000, 1'b0);
        push_item(OP_SET_MEAN, 8'd2, 32'h7fffffff, 1'b0);
        push_item(OP_INFER, 8'd2, 32'h80000000, 1'b0);
        push_item(OP_SET_VAR, 8'd3, 32'h0, 1'b1);
        push_item(OP_INFER, 8'd3, 32'h00020000, 1'b0);
        push_item(OP_SET_SCALE, 8'd255, 32'h7fffffff, 1'b0);
        push_item(OP_UNUSED_6, 8'd4, 32'hffffffff, 1'b1);
        push_item(OP_UNUSED_7, 8'd4, 32'h12345678, 1'b0);
        push_batch(1, 8'd5);
        push_item(OP_TRAIN, 8'd9, 32'h80000000, 1'b0);
        push_item(OP_TRAIN, 8'd9, 32'h7fffffff, 1'b0);
        push_item(OP_TRAIN, 8'd255, 32'h00000000, 1'b1);
        push_item(OP_INFER, 8'd255, 32'h00018000, 1'b0);
        push_batch(4, 8'd1);
        push_item(OP_INFER, 8'd5, 32'hfffe0000, 1'b0);
        drain();

        write_reg(CFG_EPSILON, 65535);
        write_reg(CFG_MOMENTUM, 65536);
        random_phase(45, 1'b0);
        drain();

        write_reg(CFG_EPSILON, 1);
        write_reg(CFG_MOMENTUM, 1);
        random_phase(60, 1'b1);
        drain();

        write_reg(CFG_EPSILON, $urandom_range(1, 65535));
        write_reg(CFG_MOMENTUM, $urandom_range(1, 65536));
        random_phase(45, 1'b0);
        drain();

        $display("%0d input transfers, %0d batches, %0d results checked, %0d mismatches",
                 n_items, n_batches, n_results, errors);
        $display("covered table loads, inference, training batches incl. overflow, 4 settings");
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
